// ===== rtl/sxtq_pkg.sv =====
// Shared types and constants of the sorted expiry timer queue.
package sxtq_pkg;

   // Commands carried in the request tuser.
   localparam logic [1:0] CMD_ADD    = 2'd0;
   localparam logic [1:0] CMD_ADJUST = 2'd1;
   localparam logic [1:0] CMD_DELETE = 2'd2;
   localparam logic [1:0] CMD_TICK   = 2'd3;

   // Result status codes carried in the response tuser.
   localparam logic [2:0] ST_DONE    = 3'd0;
   localparam logic [2:0] ST_EXPIRED = 3'd1;
   localparam logic [2:0] ST_NONE    = 3'd2;
   localparam logic [2:0] ST_BUSY    = 3'd3;
   localparam logic [2:0] ST_IDLE    = 3'd4;

   // Most results one tick may emit.
   localparam int MAX_RESULTS = 64;
   localparam int NRES_BITS   = 7;

   // Operation the datapath performs in the current cycle.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_DECODE,
      OP_RM_RD,
      OP_RM_CMP,
      OP_RM_END,
      OP_INS_RD,
      OP_INS_X,
      OP_INS_CMP,
      OP_TK_RD,
      OP_TK_X,
      OP_TK_CMP,
      OP_TK_FIN,
      OP_EMIT
   } op_type;

   // Status flags from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic is_add;
      logic is_del;
      logic bad;
      logic idx_end;
      logic idx_zero;
      logic later_ins;
      logic later_tk;
      logic tk_stop;
      logic out_free;
      logic pend_v;
   } dp_stat_type;

endpackage

// ===== rtl/sorted_expiry_timer_queue_unit.sv =====
// Top level of the sorted expiry timer queue: controller and datapath.
//
//  Channel   Direction  Ports                     Payload
//  request   in         req_tvalid/tready/tdata   tuser cmd; tdata slot, expire, tag, now
//  response  out        rsp_tvalid/tready/tdata   tuser status; tlast last; tdata slot, tag, expire
//
// One command is handled at a time; the list walk through the order memory sets its length.
// Add walks back over the k entries that expire later, whether or not it lands at the
// head; adjust and delete first walk the n entries of the list for the removal. Tick pops
// each expired item from the head. Reset is synchronous and empties the queue at once. A response
// stall holds the walk only when a finished item waits in the output register.
module sorted_expiry_timer_queue_unit
   import sxtq_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [103:0] req_tdata,  // slot[5:0], expire_time[37:6], tag[69:38], now_time[101:70]
   input  logic [1:0]   req_tuser,  // cmd[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata,  // out_slot[5:0], out_tag[37:6], out_expire[69:38]
   output logic [2:0]   rsp_tuser,  // status[2:0]
   output logic         rsp_tlast
);

   op_type               op;
   dp_stat_type          stat;
   logic [5:0]           o_slot;
   logic [TAG_BITS-1:0]  o_tag;
   logic [TIME_BITS-1:0] o_exp;

   sxtq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .stat(stat),
      .op(op), .req_tready(req_tready)
   );

   sxtq_dp #(.DEPTH(DEPTH), .TIME_BITS(TIME_BITS), .TAG_BITS(TAG_BITS)) u_dp (
      .clock(clock), .reset(reset), .op(op), .req_tvalid(req_tvalid),
      .in_cmd(req_tuser), .in_slot(req_tdata[5:0]),
      .in_expire(TIME_BITS'(req_tdata[37:6])), .in_tag(TAG_BITS'(req_tdata[69:38])),
      .in_now(TIME_BITS'(req_tdata[101:70])), .rsp_tready(rsp_tready), .stat(stat),
      .rsp_valid(rsp_tvalid), .rsp_status(rsp_tuser), .rsp_slot(o_slot),
      .rsp_tag(o_tag), .rsp_expire(o_exp), .rsp_last(rsp_tlast)
   );

   // Pack the response fields.
   assign rsp_tdata = {2'b00, 32'(o_exp), 32'(o_tag), o_slot};

endmodule

// ===== rtl/sxtq_ram.sv =====
// Simple dual-port RAM with one write port and a registered read port.
module sxtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sxtq_ctrl.sv =====
// Controller state machine of the sorted expiry timer queue.
module sxtq_ctrl
   import sxtq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  dp_stat_type stat,
   output op_type      op,
   output logic        req_tready
);

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_RM_RD, S_RM_CMP, S_RM_END, S_INS_RD, S_INS_X,
      S_INS_CMP, S_TK_RD, S_TK_X, S_TK_CMP, S_TK_FIN, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:    if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            if (stat.is_tick) state_in = S_TK_RD;
            else if (stat.bad) state_in = S_EMIT;
            else if (stat.is_add) state_in = S_INS_RD;
            else state_in = S_RM_RD;
         end
         S_RM_RD:   state_in = stat.idx_end ? S_RM_END : S_RM_CMP;
         S_RM_CMP:  state_in = S_RM_RD;
         S_RM_END:  state_in = stat.is_del ? S_EMIT : S_INS_RD;
         S_INS_RD:  state_in = stat.idx_zero ? S_EMIT : S_INS_X;
         S_INS_X:   state_in = S_INS_CMP;
         S_INS_CMP: state_in = stat.later_ins ? S_INS_RD : S_EMIT;
         S_TK_RD:   state_in = stat.tk_stop ? S_TK_FIN : S_TK_X;
         S_TK_X:    state_in = S_TK_CMP;
         S_TK_CMP: begin
            if (stat.later_tk) state_in = S_TK_FIN;
            else if (!stat.pend_v || stat.out_free) state_in = S_TK_RD;
         end
         S_TK_FIN:  state_in = S_EMIT;
         S_EMIT:    if (stat.out_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Operation issued to the datapath.
   always_comb begin
      unique case (state_ff)
         S_IDLE:    op = OP_IDLE;
         S_DECODE:  op = OP_DECODE;
         S_RM_RD:   op = OP_RM_RD;
         S_RM_CMP:  op = OP_RM_CMP;
         S_RM_END:  op = OP_RM_END;
         S_INS_RD:  op = OP_INS_RD;
         S_INS_X:   op = OP_INS_X;
         S_INS_CMP: op = OP_INS_CMP;
         S_TK_RD:   op = OP_TK_RD;
         S_TK_X:    op = OP_TK_X;
         S_TK_CMP:  op = OP_TK_CMP;
         S_TK_FIN:  op = OP_TK_FIN;
         S_EMIT:    op = OP_EMIT;
         default:   op = OP_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ===== rtl/sxtq_dp.sv =====
// Datapath of the sorted expiry timer queue: list memory, slot stores and result registers.
module sxtq_dp
   import sxtq_pkg::*;
#(
   parameter int DEPTH     = 64,
   parameter int TIME_BITS = 32,
   parameter int TAG_BITS  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  op_type               op,
   input  logic                 req_tvalid,
   input  logic [1:0]           in_cmd,
   input  logic [5:0]           in_slot,
   input  logic [TIME_BITS-1:0] in_expire,
   input  logic [TAG_BITS-1:0]  in_tag,
   input  logic [TIME_BITS-1:0] in_now,
   input  logic                 rsp_tready,
   output dp_stat_type          stat,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_status,
   output logic [5:0]           rsp_slot,
   output logic [TAG_BITS-1:0]  rsp_tag,
   output logic [TIME_BITS-1:0] rsp_expire,
   output logic                 rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // Item registers.
   logic [1:0]           cmd_ff;
   logic [5:0]           slot_ff;
   logic [TIME_BITS-1:0] exp_ff, now_ff;
   logic [TAG_BITS-1:0]  tag_ff, tag_in;

   // List control.
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in, idx_ff, idx_in;
   logic                 found_ff, found_in;
   logic [DEPTH-1:0]     active_ff, active_in;
   logic [NRES_BITS-1:0] nres_ff, nres_in;
   logic                 pend_ff, pend_in;

   // Staged result and output register.
   logic [2:0]           res_status_ff, res_status_in;
   logic [5:0]           res_slot_ff, res_slot_in;
   logic [TAG_BITS-1:0]  res_tag_ff, res_tag_in;
   logic [TIME_BITS-1:0] res_exp_ff, res_exp_in;
   logic                 res_last_ff, res_last_in;
   logic                 out_v_ff, out_v_in, out_ld;
   logic [2:0]           out_status_ff;
   logic [5:0]           out_slot_ff;
   logic [TAG_BITS-1:0]  out_tag_ff;
   logic [TIME_BITS-1:0] out_exp_ff;
   logic                 out_last_ff;

   // Memory ports.
   logic                 ord_we, ord_re, dat_re, exp_we, tag_we;
   logic [AW-1:0]        ord_wa, ord_ra, dat_ra, exp_wa;
   logic [AW-1:0]        ord_wd, ord_rd;
   logic [TIME_BITS-1:0] exp_wd, exp_rd;
   logic [TAG_BITS-1:0]  tag_rd;

   logic [AW-1:0]        s_addr;
   logic                 slot_ok, s_act, full, out_free;
   logic [CW-1:0]        idx_m1;
   logic [AW:0]          head_p1;

   // Position in memory of a list index counted from the head.
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
      logic [AW:0] s;
      s = (AW+1)'(h) + (AW+1)'(i);
      if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
      return s[AW-1:0];
   endfunction

   assign s_addr   = AW'(slot_ff);
   assign slot_ok  = (32'(slot_ff) < DEPTH);
   assign s_act    = active_ff[s_addr];
   assign full     = (count_ff == CW'(DEPTH));
   assign idx_m1   = idx_ff - CW'(1);
   assign out_free = !out_v_ff || rsp_tready;
   assign head_p1  = (AW+1)'(head_ff) + (AW+1)'(1);

   // Status toward the controller.
   always_comb begin
      stat.is_tick   = (cmd_ff == CMD_TICK);
      stat.is_add    = (cmd_ff == CMD_ADD);
      stat.is_del    = (cmd_ff == CMD_DELETE);
      stat.bad       = (cmd_ff == CMD_ADD) ? (!slot_ok || s_act || full)
                                           : (!slot_ok || !s_act);
      stat.idx_end   = (idx_ff == count_ff);
      stat.idx_zero  = (idx_ff == '0);
      stat.later_ins = (exp_rd > exp_ff);
      stat.later_tk  = (exp_rd > now_ff);
      stat.tk_stop   = (count_ff == '0) || (nres_ff == NRES_BITS'(MAX_RESULTS));
      stat.out_free  = out_free;
      stat.pend_v    = pend_ff;
   end

   // Datapath actions for each operation.
   always_comb begin
      tag_in = tag_ff;
      head_in = head_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      found_in = found_ff;
      active_in = active_ff;
      nres_in = nres_ff;
      pend_in = pend_ff;
      res_status_in = res_status_ff;
      res_slot_in = res_slot_ff;
      res_tag_in = res_tag_ff;
      res_exp_in = res_exp_ff;
      res_last_in = res_last_ff;
      out_ld = 1'b0;
      ord_we = 1'b0;
      ord_wa = phys(head_ff, idx_ff);
      ord_wd = ord_rd;
      ord_re = 1'b0;
      ord_ra = phys(head_ff, idx_ff);
      dat_re = 1'b0;
      dat_ra = ord_rd;
      exp_we = 1'b0;
      tag_we = 1'b0;
      exp_wa = s_addr;
      exp_wd = exp_ff;
      case (op)
         OP_IDLE: begin
            if (req_tvalid) tag_in = in_tag;
            nres_in = '0;
            pend_in = 1'b0;
         end
         OP_DECODE: begin
            dat_re = 1'b1;
            dat_ra = s_addr;
            res_slot_in = slot_ff;
            res_tag_in = '0;
            res_exp_in = '0;
            res_last_in = 1'b1;
            idx_in = '0;
            found_in = 1'b0;
            if (cmd_ff == CMD_ADD) begin
               res_status_in = ST_BUSY;
               if (!stat.bad) begin
                  exp_we = 1'b1;
                  tag_we = 1'b1;
                  active_in[s_addr] = 1'b1;
                  idx_in = count_ff;
               end
            end else begin
               res_status_in = ST_IDLE;
            end
         end
         OP_RM_RD: begin
            ord_re = 1'b1;
         end
         OP_RM_CMP: begin
            // Entries behind the removed one move up by one place.
            ord_we = found_ff;
            ord_wa = phys(head_ff, idx_m1);
            if (ord_rd == s_addr) found_in = 1'b1;
            idx_in = idx_ff + CW'(1);
         end
         OP_RM_END: begin
            count_in = count_ff - CW'(1);
            idx_in = count_ff - CW'(1);
            tag_in = tag_rd;
            res_status_in = ST_DONE;
            res_slot_in = slot_ff;
            res_tag_in = tag_rd;
            res_exp_in = exp_rd;
            res_last_in = 1'b1;
            if (cmd_ff == CMD_DELETE) begin
               active_in[s_addr] = 1'b0;
            end else begin
               exp_we = 1'b1;
            end
         end
         OP_INS_RD: begin
            ord_re = 1'b1;
            ord_ra = phys(head_ff, idx_m1);
            if (idx_ff == '0) begin
               ord_we = 1'b1;
               ord_wd = s_addr;
               count_in = count_ff + CW'(1);
               res_status_in = ST_DONE;
               res_slot_in = slot_ff;
               res_tag_in = tag_ff;
               res_exp_in = exp_ff;
               res_last_in = 1'b1;
            end
         end
         OP_INS_X: begin
            dat_re = 1'b1;
         end
         OP_INS_CMP: begin
            // A later entry moves back; otherwise the new timer takes this place.
            ord_we = 1'b1;
            if (stat.later_ins) begin
               idx_in = idx_m1;
            end else begin
               ord_wd = s_addr;
               count_in = count_ff + CW'(1);
               res_status_in = ST_DONE;
               res_slot_in = slot_ff;
               res_tag_in = tag_ff;
               res_exp_in = exp_ff;
               res_last_in = 1'b1;
            end
         end
         OP_TK_RD: begin
            ord_re = 1'b1;
            ord_ra = head_ff;
         end
         OP_TK_X: begin
            dat_re = 1'b1;
         end
         OP_TK_CMP: begin
            // Pop the head; the previous expired item goes out first.
            if (!stat.later_tk && (!pend_ff || out_free)) begin
               out_ld = pend_ff;
               pend_in = 1'b1;
               res_status_in = ST_EXPIRED;
               res_slot_in = 6'(ord_rd);
               res_tag_in = tag_rd;
               res_exp_in = exp_rd;
               res_last_in = 1'b0;
               head_in = (head_p1 >= (AW+1)'(DEPTH)) ? '0 : head_p1[AW-1:0];
               count_in = count_ff - CW'(1);
               active_in[ord_rd] = 1'b0;
               nres_in = nres_ff + NRES_BITS'(1);
            end
         end
         OP_TK_FIN: begin
            res_last_in = 1'b1;
            pend_in = 1'b0;
            if (!pend_ff) begin
               res_status_in = ST_NONE;
               res_slot_in = '0;
               res_tag_in = '0;
               res_exp_in = '0;
            end
         end
         OP_EMIT: begin
            out_ld = out_free;
         end
         default: begin
         end
      endcase
   end

   // Output register valid.
   always_comb begin
      out_v_in = out_v_ff;
      if (rsp_tready) out_v_in = 1'b0;
      if (out_ld) out_v_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         active_ff <= '0;
         out_v_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         count_ff <= count_in;
         active_ff <= active_in;
         out_v_ff <= out_v_in;
         pend_ff <= pend_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (op == OP_IDLE && req_tvalid) begin
         cmd_ff <= in_cmd;
         slot_ff <= in_slot;
         exp_ff <= in_expire;
         now_ff <= in_now;
      end
      tag_ff <= tag_in;
      idx_ff <= idx_in;
      found_ff <= found_in;
      nres_ff <= nres_in;
      res_status_ff <= res_status_in;
      res_slot_ff <= res_slot_in;
      res_tag_ff <= res_tag_in;
      res_exp_ff <= res_exp_in;
      res_last_ff <= res_last_in;
      if (out_ld) begin
         out_status_ff <= res_status_ff;
         out_slot_ff <= res_slot_ff;
         out_tag_ff <= res_tag_ff;
         out_exp_ff <= res_exp_ff;
         out_last_ff <= res_last_ff;
      end
   end

   // Slot order list.
   sxtq_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_order (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_en(ord_re), .rd_addr(ord_ra), .rd_data(ord_rd)
   );

   // Expiry per slot.
   sxtq_ram #(.WIDTH(TIME_BITS), .DEPTH(DEPTH)) u_expire (
      .clock(clock), .wr_en(exp_we), .wr_addr(exp_wa), .wr_data(exp_wd),
      .rd_en(dat_re), .rd_addr(dat_ra), .rd_data(exp_rd)
   );

   // Tag per slot.
   sxtq_ram #(.WIDTH(TAG_BITS), .DEPTH(DEPTH)) u_tag (
      .clock(clock), .wr_en(tag_we), .wr_addr(s_addr), .wr_data(tag_ff),
      .rd_en(dat_re), .rd_addr(dat_ra), .rd_data(tag_rd)
   );

   assign rsp_valid  = out_v_ff;
   assign rsp_status = out_status_ff;
   assign rsp_slot   = out_slot_ff;
   assign rsp_tag    = out_tag_ff;
   assign rsp_expire = out_exp_ff;
   assign rsp_last   = out_last_ff;

endmodule
